>>> hw/rtl/poi_pkg.sv
// shared types, widths, constants and arctangent table for the odometry integrator
`timescale 1ns / 1ps

package poi_pkg;

  // field widths
  localparam int DT_W       = 20;
  localparam int SPD_W      = 24;
  localparam int RATE_W     = 32;
  localparam int POS_W      = 32;
  localparam int ANG_W      = 32;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE     = 2'd2;

  // register reset values
  localparam logic signed [SPD_W-1:0]  FORWARD_SPEED_RST = 24'sd6554;
  localparam logic signed [SPD_W-1:0]  LATERAL_SPEED_RST = 24'sd0;
  localparam logic signed [RATE_W-1:0] TURN_RATE_RST     = 32'sd68356526;

  // cordic datapath, q1.30 with headroom
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CW  = 34;
  localparam int ZW  = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int ATAN_DEPTH = 30;
  localparam logic [29:0] ATAN_TABLE [ATAN_DEPTH] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // shared multiply-accumulate unit
  localparam int MAC_A_W = 33;
  localparam int MAC_B_W = DT_W + 1;
  localparam int MAC_P_W = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = 62;
  localparam int SPLIT_W = 20;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic shl;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    COR_IDLE,
    COR_RUN,
    COR_OUT
  } cordic_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TRIG1,
    ST_X0, ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6,
    ST_Y0, ST_Y1, ST_Y2, ST_Y3, ST_Y4, ST_Y5, ST_Y6,
    ST_H0, ST_H1, ST_H2,
    ST_TRIG2,
    ST_DONE
  } poi_state_t;

endpackage

>>> hw/rtl/poi_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
`timescale 1ns / 1ps

module poi_cordic import poi_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ANG_W-1:0]         angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  localparam int CNT_W = $clog2(STEPS);
  localparam int TAB_W = $clog2(ATAN_DEPTH);
  localparam int RW    = CW - 15;
  localparam logic signed [RW-1:0] R_MAX = RW'(32767);
  localparam logic signed [RW-1:0] R_MIN = -RW'(32768);

  cordic_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [CW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic                    flip_r, flip_nxt;
  logic signed [TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic                    done_r, done_nxt;

  logic                    flip;
  logic [ANG_W-1:0]        angle_adj;
  logic signed [CW-1:0]    x_sh, y_sh;
  logic signed [ZW-1:0]    atan_v;

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] s;
    logic signed [RW-1:0] r;
    s = v + CW'(16384);
    r = s[CW-1:15];
    if (r > R_MAX) begin
      r = R_MAX;
    end else if (r < R_MIN) begin
      r = R_MIN;
    end
    return TRIG_W'(r);
  endfunction

  // second and third quadrants are turned by half a turn, result negated
  assign flip      = angle[ANG_W-1] ^ angle[ANG_W-2];
  assign angle_adj = angle ^ {flip, {(ANG_W-1){1'b0}}};

  assign x_sh   = x_r >>> cnt_r;
  assign y_sh   = y_r >>> cnt_r;
  assign atan_v = ZW'(ATAN_TABLE[TAB_W'(cnt_r)]);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    flip_nxt  = flip_r;
    cos_nxt   = cos_r;
    sin_nxt   = sin_r;
    done_nxt  = 1'b0;
    case (state_r)
      COR_IDLE: begin
        if (start) begin
          x_nxt     = CORDIC_GAIN;
          y_nxt     = '0;
          z_nxt     = {angle_adj[ANG_W-1], angle_adj};
          flip_nxt  = flip;
          cnt_nxt   = '0;
          state_nxt = COR_RUN;
        end
      end
      COR_RUN: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_v;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_v;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          state_nxt = COR_OUT;
        end
      end
      COR_OUT: begin
        cos_nxt   = to_q15(flip_r ? -x_r : x_r);
        sin_nxt   = to_q15(flip_r ? -y_r : y_r);
        done_nxt  = 1'b1;
        state_nxt = COR_IDLE;
      end
      default: begin
        state_nxt = COR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= COR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign done  = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

>>> hw/rtl/poi_mac.sv
// shared signed multiply-accumulate unit, product registered before the accumulate
`timescale 1ns / 1ps

module poi_mac import poi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic signed [MAC_A_W-1:0] a,
  input  logic signed [MAC_B_W-1:0] b,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [MAC_P_W-1:0] prod_r;
  mac_ctl_t                  ctl_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   addend, base;

  // high half of a split operand lands shifted by the split width
  assign addend = ctl_r.shl ? (ACC_W'(prod_r) <<< SPLIT_W) : ACC_W'(prod_r);
  assign base   = ctl_r.clr ? '0 : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_r.en) begin
      acc_nxt = ctl_r.sub ? (base - addend) : (base + addend);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    prod_r <= a * b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

>>> hw/rtl/planar_odometry_integrator.sv
// planar dead-reckoning odometry integrator, top level and sequencer
// each item runs in order: an idle step, a cordic pass on the held heading, seventeen
// multiply-accumulate steps, a cordic pass on the half angle and a done step; no new item
// is taken until the sequencer returns to idle
// a new item is taken while the previous result still waits in the output register
// reset (synchronous, active low): position and heading zero, speeds and rate to defaults
`timescale 1ns / 1ps

module planar_odometry_integrator import poi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DT_W-1:0]          in_time_step,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic [ANG_W-1:0]         out_heading,
  output logic signed [TRIG_W-1:0] out_quat_z,
  output logic signed [TRIG_W-1:0] out_quat_w
);

  localparam int SUM_W = SPD_W + TRIG_W + 1;
  localparam int DW    = ACC_W - 31;

  poi_state_t               state_r, state_nxt;
  logic signed [SPD_W-1:0]  fs_r, fs_nxt, ls_r, ls_nxt;
  logic signed [RATE_W-1:0] tr_r, tr_nxt;
  logic signed [POS_W-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [ANG_W-1:0]         heading_r, heading_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic signed [TRIG_W-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [TRIG_W-1:0] qz_r, qz_nxt, qw_r, qw_nxt;
  logic [SPLIT_W-1:0]       lo_r, lo_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]  opx_r, opx_nxt, opy_r, opy_nxt;
  logic [ANG_W-1:0]         ohd_r, ohd_nxt;
  logic signed [TRIG_W-1:0] oqz_r, oqz_nxt, oqw_r, oqw_nxt;

  mac_ctl_t                  mac_ctl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;
  logic signed [MAC_B_W-1:0] dt_ext;
  logic signed [MAC_A_W-1:0] hi_ext;
  logic signed [ACC_W-1:0]   hd_round;

  logic                     cor_start;
  logic [ANG_W-1:0]         cor_angle;
  logic                     cor_done;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;

  // round the q16.16 step half up and add with saturation
  function automatic logic signed [POS_W-1:0] pos_add(input logic signed [POS_W-1:0] p,
                                                      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    logic signed [DW-1:0]    d;
    logic signed [POS_W:0]   sum;
    r   = v + (ACC_W'(1) <<< 30);
    d   = r[ACC_W-1:31];
    sum = (POS_W+1)'(p) + (POS_W+1)'(d);
    if (sum[POS_W] != sum[POS_W-1]) begin
      return sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return sum[POS_W-1:0];
  endfunction

  assign dt_ext   = MAC_B_W'(dt_r);
  assign hi_ext   = MAC_A_W'(signed'(acc[SUM_W-1:SPLIT_W]));
  assign hd_round = acc + (ACC_W'(1) <<< 15);

  poi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  poi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  always_comb begin
    state_nxt     = state_r;
    fs_nxt        = fs_r;
    ls_nxt        = ls_r;
    tr_nxt        = tr_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    dt_nxt        = dt_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    qz_nxt        = qz_r;
    qw_nxt        = qw_r;
    lo_nxt        = lo_r;
    opx_nxt       = opx_r;
    opy_nxt       = opy_r;
    ohd_nxt       = ohd_r;
    oqz_nxt       = oqz_r;
    oqw_nxt       = oqw_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cor_start     = 1'b0;
    cor_angle     = heading_r;
    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_FORWARD_SPEED: fs_nxt = cfg_data[SPD_W-1:0];
        CFG_LATERAL_SPEED: ls_nxt = cfg_data[SPD_W-1:0];
        CFG_TURN_RATE:     tr_nxt = cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        // no transfer while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          dt_nxt    = in_time_step;
          cor_start = 1'b1;
          state_nxt = ST_TRIG1;
        end
      end
      ST_TRIG1: begin
        if (cor_done) begin
          c_nxt     = cor_cos;
          s_nxt     = cor_sin;
          state_nxt = ST_X0;
        end
      end
      // dx: fs*c - ls*s, then times dt in two halves
      ST_X0: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
        mac_a     = MAC_A_W'(fs_r);
        mac_b     = MAC_B_W'(c_r);
        state_nxt = ST_X1;
      end
      ST_X1: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, shl: 1'b0};
        mac_a     = MAC_A_W'(ls_r);
        mac_b     = MAC_B_W'(s_r);
        state_nxt = ST_X2;
      end
      ST_X2: begin
        state_nxt = ST_X3;
      end
      ST_X3: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b1};
        mac_a     = hi_ext;
        mac_b     = dt_ext;
        lo_nxt    = acc[SPLIT_W-1:0];
        state_nxt = ST_X4;
      end
      ST_X4: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
        mac_a     = MAC_A_W'(lo_r);
        mac_b     = dt_ext;
        state_nxt = ST_X5;
      end
      ST_X5: begin
        state_nxt = ST_X6;
      end
      ST_X6: begin
        pos_x_nxt = pos_add(pos_x_r, acc);
        state_nxt = ST_Y0;
      end
      // dy: fs*s + ls*c, then times dt
      ST_Y0: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
        mac_a     = MAC_A_W'(fs_r);
        mac_b     = MAC_B_W'(s_r);
        state_nxt = ST_Y1;
      end
      ST_Y1: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
        mac_a     = MAC_A_W'(ls_r);
        mac_b     = MAC_B_W'(c_r);
        state_nxt = ST_Y2;
      end
      ST_Y2: begin
        state_nxt = ST_Y3;
      end
      ST_Y3: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b1};
        mac_a     = hi_ext;
        mac_b     = dt_ext;
        lo_nxt    = acc[SPLIT_W-1:0];
        state_nxt = ST_Y4;
      end
      ST_Y4: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
        mac_a     = MAC_A_W'(lo_r);
        mac_b     = dt_ext;
        state_nxt = ST_Y5;
      end
      ST_Y5: begin
        state_nxt = ST_Y6;
      end
      ST_Y6: begin
        pos_y_nxt = pos_add(pos_y_r, acc);
        state_nxt = ST_H0;
      end
      ST_H0: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
        mac_a     = MAC_A_W'(tr_r);
        mac_b     = dt_ext;
        state_nxt = ST_H1;
      end
      ST_H1: begin
        state_nxt = ST_H2;
      end
      ST_H2: begin
        // heading wraps; quaternion trig runs on the half angle
        heading_nxt = heading_r + hd_round[ANG_W+15:16];
        cor_start   = 1'b1;
        cor_angle   = {1'b0, heading_nxt[ANG_W-1:1]};
        state_nxt   = ST_TRIG2;
      end
      ST_TRIG2: begin
        if (cor_done) begin
          qz_nxt    = cor_sin;
          qw_nxt    = cor_cos;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          opx_nxt       = pos_x_r;
          opy_nxt       = pos_y_r;
          ohd_nxt       = heading_r;
          oqz_nxt       = qz_r;
          oqw_nxt       = qw_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fs_r        <= FORWARD_SPEED_RST;
      ls_r        <= LATERAL_SPEED_RST;
      tr_r        <= TURN_RATE_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fs_r        <= fs_nxt;
      ls_r        <= ls_nxt;
      tr_r        <= tr_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dt_r  <= dt_nxt;
    c_r   <= c_nxt;
    s_r   <= s_nxt;
    qz_r  <= qz_nxt;
    qw_r  <= qw_nxt;
    lo_r  <= lo_nxt;
    opx_r <= opx_nxt;
    opy_r <= opy_nxt;
    ohd_r <= ohd_nxt;
    oqz_r <= oqz_nxt;
    oqw_r <= oqw_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = opx_r;
  assign out_pos_y   = opy_r;
  assign out_heading = ohd_r;
  assign out_quat_z  = oqz_r;
  assign out_quat_w  = oqw_r;

endmodule

>>> tb/sv/planar_odometry_integrator_test.sv
// self-checking testbench for the planar odometry integrator
`timescale 1ns / 1ps

module planar_odometry_integrator_test;
  import poi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [DT_W-1:0]      DT_MAX    = '1;
  localparam int unsigned          CYCLE_LIMIT = 600000;
  localparam int unsigned          RANDOM_PHASES = 6;
  localparam int unsigned          TICKS_PER_PHASE = 300;
  localparam int                   ROT_STEPS = 16;
  localparam longint               ROT_GAIN_Q30 = 652032874;
  localparam longint               ARCTAN_Q30 [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef enum int {
    SET_GENTLE,
    SET_STRAIGHT,
    SET_WILD,
    SET_EXTREME
  } setting_kind_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [ANG_W-1:0]         heading;
    logic signed [TRIG_W-1:0] qz;
    logic signed [TRIG_W-1:0] qw;
  } pose_t;

  class pose_scoreboard;
    longint                  fwd;
    longint                  lat;
    longint                  yaw_rate;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [ANG_W-1:0]        hd;
    pose_t                   expected_poses[$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             limit_hits;
    int unsigned             wraps;

    function new();
      // power-on register defaults: 0.1 m/s forward, 0.1 rad/s turn
      fwd = 6554;
      lat = 0;
      yaw_rate = 68356526;
      px = '0;
      py = '0;
      hd = '0;
      errors = 0;
      checked = 0;
      limit_hits = 0;
      wraps = 0;
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction

    function void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FORWARD_SPEED: fwd = longint'($signed(data[SPD_W-1:0]));
        CFG_LATERAL_SPEED: lat = longint'($signed(data[SPD_W-1:0]));
        CFG_TURN_RATE:     yaw_rate = longint'($signed(data[RATE_W-1:0]));
        default: ;
      endcase
    endfunction

    function longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp_q15(input longint v);
      longint r;
      r = round_half_up(v, 15);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[POS_W-1:0];
    endfunction

    // q1.15 cosine and sine of a binary angle
    function void sin_cos(input logic [ANG_W-1:0] ang, output longint c, output longint s);
      logic [ANG_W-1:0] a;
      bit               flip;
      longint           x, y, z, nx;
      a = ang;
      flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      // fold the back half-plane onto the front one and negate afterwards
      if (flip) a = a - 32'h8000_0000;
      z = longint'($signed(a));
      x = ROT_GAIN_Q30;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - ARCTAN_Q30[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + ARCTAN_Q30[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = clamp_q15(x);
      s = clamp_q15(y);
    endfunction

    function void note_tick(input logic [DT_W-1:0] dt);
      longint step, c, s, dx, dy, turn, hsum, qz, qw;
      pose_t  p;
      step = longint'(dt);
      // motion uses the heading held before this tick
      sin_cos(hd, c, s);
      dx = round_half_up((fwd * c - lat * s) * step, 31);
      dy = round_half_up((fwd * s + lat * c) * step, 31);
      px = clamp_pos(longint'(px) + dx);
      py = clamp_pos(longint'(py) + dy);
      turn = round_half_up(yaw_rate * step, 16);
      hsum = longint'(hd) + turn;
      if (hsum < 0 || hsum > 64'sh0_FFFF_FFFF) wraps++;
      hd = hsum[ANG_W-1:0];
      sin_cos({1'b0, hd[ANG_W-1:1]}, qw, qz);
      p.x = px;
      p.y = py;
      p.heading = hd;
      p.qz = qz[TRIG_W-1:0];
      p.qw = qw[TRIG_W-1:0];
      if (px == 32'sh7FFF_FFFF || px == 32'sh8000_0000 ||
          py == 32'sh7FFF_FFFF || py == 32'sh8000_0000) limit_hits++;
      expected_poses.push_back(p);
    endfunction

    function void compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pose(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                             input logic [ANG_W-1:0] heading, input logic signed [TRIG_W-1:0] qz,
                             input logic signed [TRIG_W-1:0] qw);
      pose_t want;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected pose, expected none actual x=%0d y=%0d heading=%0d",
                 $time, x, y, heading);
        return;
      end
      want = expected_poses.pop_front();
      checked++;
      compare_field("pos_x", want.x, x);
      compare_field("pos_y", want.y, y);
      compare_field("heading", longint'(want.heading), longint'(heading));
      compare_field("quat_z", want.qz, qz);
      compare_field("quat_w", want.qw, qw);
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [DT_W-1:0]          in_time_step;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic [ANG_W-1:0]         out_heading;
  logic signed [TRIG_W-1:0] out_quat_z;
  logic signed [TRIG_W-1:0] out_quat_w;

  pose_scoreboard sb;
  bit             gaps_on;
  int unsigned    cycles;
  int unsigned    ticks_sent;
  int unsigned    settings_used;

  planar_odometry_integrator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_time_step (in_time_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_heading  (out_heading),
    .out_quat_z   (out_quat_z),
    .out_quat_w   (out_quat_w)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("FAIL planar_odometry_integrator");
      $finish;
    end
  end

  // result side: check at the rising edge, change ready at the falling one
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_pose(out_pos_x, out_pos_y, out_heading, out_quat_z, out_quat_w);
      @(negedge clk);
      out_ready <= !(gaps_on && $urandom_range(99) < 16);
    end
  end

  // entered just after a falling edge, returns just after one
  task automatic send_tick(input logic [DT_W-1:0] dt);
    if (gaps_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 16);
    end
    in_valid <= 1'b1;
    in_time_step <= dt;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(dt);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.apply_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // upper byte of the speed words is stray and must be ignored
  task automatic pick_setting(input setting_kind_t kind);
    logic [CFG_DATA_W-1:0] fs, ls, tr;
    fs = $urandom;
    ls = $urandom;
    tr = $urandom;
    case (kind)
      SET_GENTLE: begin
        fs[23:17] = {7{fs[17]}};
        ls[23:17] = {7{ls[17]}};
      end
      SET_STRAIGHT: tr[31:19] = {13{tr[19]}};
      SET_EXTREME: begin
        fs[23:0] = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
        ls[23:0] = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
        tr = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      default: ;
    endcase
    write_reg(CFG_FORWARD_SPEED, fs);
    write_reg(CFG_LATERAL_SPEED, ls);
    write_reg(CFG_TURN_RATE, tr);
    write_reg(CFG_SPARE, $urandom);
    settings_used++;
  endtask

  function automatic logic [DT_W-1:0] random_dt();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return DT_MAX;
    if (r < 60) return DT_W'($urandom_range(8191));
    return DT_W'($urandom);
  endfunction

  initial begin
    setting_kind_t kind;
    sb = new();
    gaps_on = 1'b1;
    ticks_sent = 0;
    settings_used = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FORWARD_SPEED;
    cfg_data = '0;
    in_valid = 1'b0;
    in_time_step = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default settings: zero step first so the unit cosine clamp is seen
    send_tick('0);
    send_tick(20'd1);
    send_tick(DT_MAX);
    send_tick(20'h55555);
    send_tick(20'hAAAAA);
    send_tick(20'h10000);
    drain();

    // speed and rate extremes, large steps drive saturation and heading wrap
    write_reg(CFG_FORWARD_SPEED, {8'hA5, 24'h7F_FFFF});
    write_reg(CFG_LATERAL_SPEED, {8'hFF, 24'h00_0000});
    write_reg(CFG_TURN_RATE, 32'h7FFF_FFFF);
    settings_used++;
    repeat (6) send_tick(DT_MAX);
    drain();
    write_reg(CFG_FORWARD_SPEED, {8'h5A, 24'h80_0000});
    write_reg(CFG_LATERAL_SPEED, {8'h00, 24'h80_0000});
    write_reg(CFG_TURN_RATE, 32'h8000_0000);
    settings_used++;
    repeat (6) send_tick(DT_MAX);
    drain();

    // unknown register index leaves every setting alone
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    send_tick(DT_MAX);
    send_tick(20'd12345);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = setting_kind_t'(phase % 4);
      pick_setting(kind);
      // one phase runs both sides flat out
      gaps_on = (phase != 3);
      repeat (TICKS_PER_PHASE) send_tick(random_dt());
      drain();
    end
    gaps_on = 1'b1;

    // latency allowance so a stray late result is still caught
    repeat (70) @(negedge clk);
    $display("covered %0d ticks over %0d register settings, %0d poses checked",
             ticks_sent, settings_used, sb.checked);
    $display("%0d poses at a position limit, %0d heading wraps", sb.limit_hits, sb.wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS planar_odometry_integrator");
    end else begin
      $display("FAIL planar_odometry_integrator");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/poi_pkg.sv
hw/rtl/poi_cordic.sv
hw/rtl/poi_mac.sv
hw/rtl/planar_odometry_integrator.sv
tb/sv/planar_odometry_integrator_test.sv
